>>> sv/crcr_pkg.sv
// shared types and constants for the capture ring channel remapper
`timescale 1ns / 1ps
`default_nettype none

package crcr_pkg;

  // frame geometry
  localparam int unsigned SLOTS        = 8;
  localparam int unsigned SAMPLE_W     = 24;
  localparam int unsigned POS_W        = 15;
  localparam int unsigned REG_W        = 16;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned SURROUND_51  = 6;

  // longest period in frames
  localparam logic [REG_W-1:0] PERIOD_LIMIT = 16'h8000;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPTURE_ENABLE = 3'd0,
    CFG_CHANNEL_LAYOUT = 3'd1,
    CFG_SAMPLE_IS_WIDE = 3'd2,
    CFG_RING_FRAMES    = 3'd3,
    CFG_PERIOD_FRAMES  = 3'd4
  } cfg_idx_e;

  // channel layout codes, the unused code behaves as 7.1
  typedef enum logic [1:0] {
    LAYOUT_STEREO = 2'd0,
    LAYOUT_51     = 2'd1,
    LAYOUT_71     = 2'd2
  } layout_e;

  // output channel to transport slot maps
  localparam logic [2:0] MAP_51 [SURROUND_51] = '{3'd0, 3'd1, 3'd4, 3'd5, 3'd2, 3'd3};
  localparam logic [2:0] MAP_71 [SLOTS] =
    '{3'd0, 3'd1, 3'd2, 3'd3, 3'd6, 3'd7, 3'd4, 3'd5};

  // configuration register set
  typedef struct packed {
    logic             capture_enable;
    logic [1:0]       channel_layout;
    logic             sample_is_wide;
    logic [REG_W-1:0] ring_frames;
    logic [REG_W-1:0] period_frames;
  } cfg_t;

  // one capture frame
  typedef struct packed {
    logic [SLOTS-1:0][SAMPLE_W-1:0] slot;
    logic                           chunk_end;
  } frame_t;

  // one remapped result
  typedef struct packed {
    logic [POS_W-1:0]               ring_position;
    logic [SLOTS-1:0][SAMPLE_W-1:0] chan;
    logic                           period_elapsed;
    logic                           chunk_end_out;
  } result_t;

endpackage

`default_nettype wire

>>> sv/crcr_if.sv
// frame and result stream interfaces
`timescale 1ns / 1ps
`default_nettype none

interface crcr_frame_if;
  logic        valid;
  logic        ready;
  logic [23:0] slot_0;
  logic [23:0] slot_1;
  logic [23:0] slot_2;
  logic [23:0] slot_3;
  logic [23:0] slot_4;
  logic [23:0] slot_5;
  logic [23:0] slot_6;
  logic [23:0] slot_7;
  logic        chunk_end;

  modport source (
    output valid, slot_0, slot_1, slot_2, slot_3, slot_4, slot_5, slot_6, slot_7,
    output chunk_end,
    input  ready
  );
  modport sink (
    input  valid, slot_0, slot_1, slot_2, slot_3, slot_4, slot_5, slot_6, slot_7,
    input  chunk_end,
    output ready
  );
endinterface

interface crcr_result_if;
  logic        valid;
  logic        ready;
  logic [14:0] ring_position;
  logic [23:0] chan_0;
  logic [23:0] chan_1;
  logic [23:0] chan_2;
  logic [23:0] chan_3;
  logic [23:0] chan_4;
  logic [23:0] chan_5;
  logic [23:0] chan_6;
  logic [23:0] chan_7;
  logic        period_elapsed;
  logic        chunk_end_out;

  modport source (
    output valid, ring_position, chan_0, chan_1, chan_2, chan_3, chan_4, chan_5,
    output chan_6, chan_7, period_elapsed, chunk_end_out,
    input  ready
  );
  modport sink (
    input  valid, ring_position, chan_0, chan_1, chan_2, chan_3, chan_4, chan_5,
    input  chan_6, chan_7, period_elapsed, chunk_end_out,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/crcr_cfg_regs.sv
// configuration register file
`timescale 1ns / 1ps
`default_nettype none

module crcr_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [crcr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [crcr_pkg::REG_W-1:0]     cfg_data_i,
  output crcr_pkg::cfg_t                      cfg_o
);

  crcr_pkg::cfg_t cfg_q;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capture_enable <= 1'b0;
      cfg_q.channel_layout <= crcr_pkg::LAYOUT_STEREO;
      cfg_q.sample_is_wide <= 1'b0;
      cfg_q.ring_frames    <= 16'd4096;
      cfg_q.period_frames  <= 16'd1024;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        crcr_pkg::CFG_CAPTURE_ENABLE: cfg_q.capture_enable <= cfg_data_i[0];
        crcr_pkg::CFG_CHANNEL_LAYOUT: cfg_q.channel_layout <= cfg_data_i[1:0];
        crcr_pkg::CFG_SAMPLE_IS_WIDE: cfg_q.sample_is_wide <= cfg_data_i[0];
        crcr_pkg::CFG_RING_FRAMES:    cfg_q.ring_frames    <= cfg_data_i;
        crcr_pkg::CFG_PERIOD_FRAMES:  cfg_q.period_frames  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> sv/crcr_in_stage.sv
// input register stage for capture frames
`timescale 1ns / 1ps
`default_nettype none

module crcr_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  crcr_frame_if.sink      frame_i,
  output logic            s1_valid_o,
  output crcr_pkg::frame_t s1_frame_o,
  input  wire logic       s1_ready_i
);

  logic             valid_q;
  crcr_pkg::frame_t frame_q;
  crcr_pkg::frame_t frame_d;
  logic             take;

  // gather the beat into one word
  always_comb begin
    frame_d.slot[0]   = frame_i.slot_0;
    frame_d.slot[1]   = frame_i.slot_1;
    frame_d.slot[2]   = frame_i.slot_2;
    frame_d.slot[3]   = frame_i.slot_3;
    frame_d.slot[4]   = frame_i.slot_4;
    frame_d.slot[5]   = frame_i.slot_5;
    frame_d.slot[6]   = frame_i.slot_6;
    frame_d.slot[7]   = frame_i.slot_7;
    frame_d.chunk_end = frame_i.chunk_end;
  end

  // stage is free when empty or draining this cycle
  assign frame_i.ready = !valid_q || s1_ready_i;
  assign take          = frame_i.valid && frame_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (frame_i.ready) begin
      valid_q <= frame_i.valid;
    end
  end

  // payload holds no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      frame_q <= frame_d;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_frame_o = frame_q;

endmodule

`default_nettype wire

>>> sv/crcr_remap_stage.sv
// channel remap, ring position and period counters with result register
`timescale 1ns / 1ps
`default_nettype none

module crcr_remap_stage #(
  parameter logic [crcr_pkg::REG_W-1:0] RING_CAP = 16'd32768
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire crcr_pkg::cfg_t   cfg_i,
  input  wire logic             s1_valid_i,
  input  wire crcr_pkg::frame_t s1_frame_i,
  output logic                  s1_ready_o,
  crcr_result_if.source         result_o
);

  localparam int unsigned PW = crcr_pkg::POS_W;
  localparam int unsigned RW = crcr_pkg::REG_W;

  logic                                         out_valid_q;
  crcr_pkg::result_t                            res_q;
  crcr_pkg::result_t                            res_d;
  logic [PW-1:0]                                wr_pos_q;
  logic [PW-1:0]                                wr_pos_d;
  logic [PW-1:0]                                period_q;
  logic [PW-1:0]                                period_d;
  logic [crcr_pkg::SLOTS-1:0][crcr_pkg::SAMPLE_W-1:0] slot;
  logic [RW-1:0]                                ring_sat;
  logic [RW-1:0]                                period_sat;
  logic [RW-1:0]                                pos;
  logic [RW-1:0]                                next_pos;
  logic [RW-1:0]                                cnt;
  logic                                         elapsed;
  logic                                         keep;
  logic                                         take;

  // frames pass only when enabled and both lengths are non-zero
  assign keep = cfg_i.capture_enable && (cfg_i.ring_frames != '0) &&
                (cfg_i.period_frames != '0);

  assign s1_ready_o = !out_valid_q || result_o.ready;
  assign take       = s1_valid_i && s1_ready_o;

  // length saturation
  assign ring_sat   = (cfg_i.ring_frames > RING_CAP) ? RING_CAP : cfg_i.ring_frames;
  assign period_sat = (cfg_i.period_frames > crcr_pkg::PERIOD_LIMIT) ?
                      crcr_pkg::PERIOD_LIMIT : cfg_i.period_frames;

  // ring write position, restarts at zero when past the ring
  always_comb begin
    pos = {1'b0, wr_pos_q};
    if (pos >= ring_sat) begin
      pos = '0;
    end
    next_pos = pos + 16'd1;
    if (next_pos >= ring_sat) begin
      next_pos = '0;
    end
    wr_pos_d = next_pos[PW-1:0];
  end

  // period counter and elapsed flag
  always_comb begin
    cnt      = {1'b0, period_q} + 16'd1;
    elapsed  = (cnt >= period_sat);
    period_d = elapsed ? '0 : cnt[PW-1:0];
  end

  // sample width mask then channel reorder
  always_comb begin
    for (int i = 0; i < crcr_pkg::SLOTS; i++) begin
      slot[i] = cfg_i.sample_is_wide ? s1_frame_i.slot[i] :
                {8'h00, s1_frame_i.slot[i][15:0]};
    end
    res_d.chan = '0;
    case (cfg_i.channel_layout)
      crcr_pkg::LAYOUT_STEREO: begin
        res_d.chan[0] = slot[0];
        res_d.chan[1] = slot[1];
      end
      crcr_pkg::LAYOUT_51: begin
        for (int i = 0; i < crcr_pkg::SURROUND_51; i++) begin
          res_d.chan[i] = slot[crcr_pkg::MAP_51[i]];
        end
      end
      default: begin
        for (int i = 0; i < crcr_pkg::SLOTS; i++) begin
          res_d.chan[i] = slot[crcr_pkg::MAP_71[i]];
        end
      end
    endcase
    res_d.ring_position  = pos[PW-1:0];
    res_d.period_elapsed = elapsed;
    res_d.chunk_end_out  = s1_frame_i.chunk_end;
  end

  // control state: result valid and ring counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      wr_pos_q    <= '0;
      period_q    <= '0;
    end else begin
      if (take) begin
        out_valid_q <= keep;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (take && keep) begin
        wr_pos_q <= wr_pos_d;
        period_q <= period_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (take && keep) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.ring_position  = res_q.ring_position;
  assign result_o.chan_0         = res_q.chan[0];
  assign result_o.chan_1         = res_q.chan[1];
  assign result_o.chan_2         = res_q.chan[2];
  assign result_o.chan_3         = res_q.chan[3];
  assign result_o.chan_4         = res_q.chan[4];
  assign result_o.chan_5         = res_q.chan[5];
  assign result_o.chan_6         = res_q.chan[6];
  assign result_o.chan_7         = res_q.chan[7];
  assign result_o.period_elapsed = res_q.period_elapsed;
  assign result_o.chunk_end_out  = res_q.chunk_end_out;

endmodule

`default_nettype wire

>>> sv/capture_ring_channel_remap.sv
// Capture ring channel remapper: takes one capture frame of eight 24-bit slots per beat
// and, while capture is enabled, reorders the slots into stereo, 5.1 or 7.1 channel order,
// masks them to 16 or 24 bits, and tags each frame with its ring write position and a
// period-elapsed flag. A frame is accepted every clock cycle unless the output stalls.
// Each frame goes through the input register, the remap and wrap counters, and the result
// register. Frames taken while capture is disabled, or while the ring or period length is
// zero, give no result and leave the counters alone. The user must write registers through
// the plain write port only while no frame is in flight; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module capture_ring_channel_remap #(
  parameter int unsigned RING_FRAMES_MAX = 32768
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [crcr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [crcr_pkg::REG_W-1:0]     cfg_data_i,
  crcr_frame_if.sink                          frame_i,
  crcr_result_if.source                       result_o
);

  // ring length cap as seen by the 16-bit register
  localparam int unsigned RING_CAP_INT =
    (RING_FRAMES_MAX > 65535) ? 65535 : RING_FRAMES_MAX;
  localparam logic [crcr_pkg::REG_W-1:0] RING_CAP = RING_CAP_INT[crcr_pkg::REG_W-1:0];

  crcr_pkg::cfg_t   cfg;
  logic             s1_valid;
  logic             s1_ready;
  crcr_pkg::frame_t s1_frame;

  // register file
  crcr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // input register
  crcr_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .frame_i    (frame_i),
    .s1_valid_o (s1_valid),
    .s1_frame_o (s1_frame),
    .s1_ready_i (s1_ready)
  );

  // remap and result register
  crcr_remap_stage #(
    .RING_CAP (RING_CAP)
  ) u_remap (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .s1_valid_i (s1_valid),
    .s1_frame_i (s1_frame),
    .s1_ready_o (s1_ready),
    .result_o   (result_o)
  );

endmodule

`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for the capture ring channel remapper
`timescale 1ns / 1ps

module testbench;

  // ring length the block is built with
  localparam int unsigned RING_LIMIT = 32768;
  // layout code with no name of its own, treated as 7.1
  localparam logic [1:0] LAYOUT_SPARE = 2'd3;
  // cycles to let a dropped frame leave the pipeline
  localparam int unsigned SETTLE_CYCLES = 6;
  // frames sent in total, and where the quiet tail starts
  localparam int unsigned SENT_TARGET = 450;
  localparam int unsigned CALM_FROM   = 390;

  // per-frame predictor of the remap, ring position and period flag
  class remap_scoreboard;
    crcr_pkg::cfg_t                  regs;
    logic [crcr_pkg::POS_W-1:0]      wr_pos;
    logic [crcr_pkg::POS_W-1:0]      per_cnt;
    crcr_pkg::result_t               pending[$];
    int unsigned                     frames_kept;
    int unsigned                     errors;
    logic [2:0]                      ord_51[crcr_pkg::SURROUND_51];
    logic [2:0]                      ord_71[crcr_pkg::SLOTS];

    function new();
      regs.capture_enable = 1'b0;
      regs.channel_layout = crcr_pkg::LAYOUT_STEREO;
      regs.sample_is_wide = 1'b0;
      regs.ring_frames    = 16'd4096;
      regs.period_frames  = 16'd1024;
      wr_pos      = '0;
      per_cnt     = '0;
      frames_kept = 0;
      errors      = 0;
      ord_51 = '{3'd0, 3'd1, 3'd4, 3'd5, 3'd2, 3'd3};
      ord_71 = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd6, 3'd7, 3'd4, 3'd5};
    endfunction

    function void write_reg(crcr_pkg::cfg_idx_e idx, logic [crcr_pkg::REG_W-1:0] data);
      case (idx)
        crcr_pkg::CFG_CAPTURE_ENABLE: regs.capture_enable = data[0];
        crcr_pkg::CFG_CHANNEL_LAYOUT: regs.channel_layout = data[1:0];
        crcr_pkg::CFG_SAMPLE_IS_WIDE: regs.sample_is_wide = data[0];
        crcr_pkg::CFG_RING_FRAMES:    regs.ring_frames    = data;
        crcr_pkg::CFG_PERIOD_FRAMES:  regs.period_frames  = data;
        default: ;
      endcase
    endfunction

    // work out the result of one accepted frame, if it gives one
    function void note_frame(crcr_pkg::frame_t f);
      int unsigned                                        ring;
      int unsigned                                        period;
      int unsigned                                        pos;
      int unsigned                                        nxt;
      int unsigned                                        cnt;
      logic [crcr_pkg::SAMPLE_W-1:0]                      mask;
      logic [crcr_pkg::SLOTS-1:0][crcr_pkg::SAMPLE_W-1:0] s;
      crcr_pkg::result_t                                  r;
      if (!regs.capture_enable) return;
      ring   = 32'(regs.ring_frames);
      period = 32'(regs.period_frames);
      if (ring == 0 || period == 0) return;
      if (ring > RING_LIMIT) ring = RING_LIMIT;
      if (period > crcr_pkg::PERIOD_LIMIT) period = 32'(crcr_pkg::PERIOD_LIMIT);

      mask = regs.sample_is_wide ? 24'hFFFFFF : 24'h00FFFF;
      for (int i = 0; i < crcr_pkg::SLOTS; i++) s[i] = f.slot[i] & mask;
      r = '0;
      case (regs.channel_layout)
        crcr_pkg::LAYOUT_STEREO: begin
          r.chan[0] = s[0];
          r.chan[1] = s[1];
        end
        crcr_pkg::LAYOUT_51: begin
          for (int i = 0; i < crcr_pkg::SURROUND_51; i++) r.chan[i] = s[ord_51[i]];
        end
        default: begin
          for (int i = 0; i < crcr_pkg::SLOTS; i++) r.chan[i] = s[ord_71[i]];
        end
      endcase

      // a position left past a shrunk ring restarts at zero
      pos = 32'(wr_pos);
      if (pos >= ring) pos = 0;
      nxt = pos + 1;
      if (nxt >= ring) nxt = 0;
      wr_pos = nxt[crcr_pkg::POS_W-1:0];

      // a count already past the period still flags and restarts
      cnt = per_cnt + 1;
      r.period_elapsed = (cnt >= period);
      if (cnt >= period) cnt = 0;
      per_cnt = cnt[crcr_pkg::POS_W-1:0];

      r.ring_position = pos[crcr_pkg::POS_W-1:0];
      r.chunk_end_out = f.chunk_end;
      pending.push_back(r);
      frames_kept++;
    endfunction

    function void compare_field(string field, logic [crcr_pkg::SAMPLE_W-1:0] want,
                                logic [crcr_pkg::SAMPLE_W-1:0] seen);
      if (seen !== want) begin
        $display("%0t %s expected %h actual %h", $time, field, want, seen);
        errors++;
      end
    endfunction

    // compare one accepted result beat with the oldest expectation
    function void check_result(crcr_pkg::result_t got);
      crcr_pkg::result_t want;
      if (pending.size() == 0) begin
        $display("%0t result with none expected, actual position %h",
                 $time, got.ring_position);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("ring_position", crcr_pkg::SAMPLE_W'(want.ring_position),
                    crcr_pkg::SAMPLE_W'(got.ring_position));
      for (int i = 0; i < crcr_pkg::SLOTS; i++)
        compare_field($sformatf("chan_%0d", i), want.chan[i], got.chan[i]);
      compare_field("period_elapsed", crcr_pkg::SAMPLE_W'(want.period_elapsed),
                    crcr_pkg::SAMPLE_W'(got.period_elapsed));
      compare_field("chunk_end_out", crcr_pkg::SAMPLE_W'(want.chunk_end_out),
                    crcr_pkg::SAMPLE_W'(got.chunk_end_out));
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we;
  logic [crcr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [crcr_pkg::REG_W-1:0]     cfg_data;
  bit                             calm;
  int unsigned                    frames_sent;
  remap_scoreboard                board;

  crcr_frame_if  frame_if ();
  crcr_result_if result_if ();

  capture_ring_channel_remap u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .frame_i     (frame_if),
    .result_o    (result_if)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // result side: ready with random stall bursts, none in the quiet tail
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        result_if.ready <= 1'b0;
        stall_left--;
      end else begin
        result_if.ready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 7);
      end
    end
  end

  // check every accepted result beat
  always @(posedge clk_i) begin : result_monitor
    crcr_pkg::result_t got;
    if (rst_ni === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      got.ring_position  = result_if.ring_position;
      got.chan[0]        = result_if.chan_0;
      got.chan[1]        = result_if.chan_1;
      got.chan[2]        = result_if.chan_2;
      got.chan[3]        = result_if.chan_3;
      got.chan[4]        = result_if.chan_4;
      got.chan[5]        = result_if.chan_5;
      got.chan[6]        = result_if.chan_6;
      got.chan[7]        = result_if.chan_7;
      got.period_elapsed = result_if.period_elapsed;
      got.chunk_end_out  = result_if.chunk_end_out;
      board.check_result(got);
    end
  end

  // drive one frame beat and wait for it to be taken
  task automatic send_frame(input crcr_pkg::frame_t f);
    if (!calm && $urandom_range(0, 4) == 0) begin
      frame_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    frame_if.valid     <= 1'b1;
    frame_if.slot_0    <= f.slot[0];
    frame_if.slot_1    <= f.slot[1];
    frame_if.slot_2    <= f.slot[2];
    frame_if.slot_3    <= f.slot[3];
    frame_if.slot_4    <= f.slot[4];
    frame_if.slot_5    <= f.slot[5];
    frame_if.slot_6    <= f.slot[6];
    frame_if.slot_7    <= f.slot[7];
    frame_if.chunk_end <= f.chunk_end;
    @(posedge clk_i);
    while (frame_if.ready !== 1'b1) @(posedge clk_i);
    board.note_frame(f);
    frames_sent++;
    @(negedge clk_i);
  endtask

  // hold the sender until every result is in and the pipe is empty
  task automatic wait_drained();
    frame_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(input crcr_pkg::cfg_idx_e idx,
                           input logic [crcr_pkg::REG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    board.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic set_one(input crcr_pkg::cfg_idx_e idx,
                         input logic [crcr_pkg::REG_W-1:0] data);
    wait_drained();
    cfg_write(idx, data);
    cfg_we <= 1'b0;
  endtask

  // unused upper data bits are filled at random
  task automatic configure(input bit en, input logic [1:0] layout, input bit wide,
                           input logic [crcr_pkg::REG_W-1:0] ring,
                           input logic [crcr_pkg::REG_W-1:0] period);
    wait_drained();
    cfg_write(crcr_pkg::CFG_CAPTURE_ENABLE, {15'($urandom), en});
    cfg_write(crcr_pkg::CFG_CHANNEL_LAYOUT, {14'($urandom), layout});
    cfg_write(crcr_pkg::CFG_SAMPLE_IS_WIDE, {15'($urandom), wide});
    cfg_write(crcr_pkg::CFG_RING_FRAMES, ring);
    cfg_write(crcr_pkg::CFG_PERIOD_FRAMES, period);
    cfg_we <= 1'b0;
  endtask

  function automatic crcr_pkg::frame_t rand_frame();
    crcr_pkg::frame_t f;
    for (int i = 0; i < crcr_pkg::SLOTS; i++) begin
      case ($urandom_range(0, 7))
        0:       f.slot[i] = '0;
        1:       f.slot[i] = '1;
        2:       f.slot[i] = 24'h00FFFF;
        3:       f.slot[i] = 24'hFF0000;
        default: f.slot[i] = 24'($urandom);
      endcase
    end
    f.chunk_end = 1'($urandom_range(0, 1));
    return f;
  endfunction

  // ring and period lengths: mostly short, with the edges mixed in
  function automatic logic [crcr_pkg::REG_W-1:0] pick_len();
    case ($urandom_range(0, 19))
      0:       return '0;
      1, 2:    return 16'd1;
      3:       return 16'hFFFF;
      4:       return 16'h8000;
      5:       return 16'h7FFF;
      6:       return 16'h8001;
      7:       return 16'($urandom);
      default: return 16'($urandom_range(2, 12));
    endcase
  endfunction

  // stimulus
  initial begin : stimulus
    crcr_pkg::frame_t f;
    int unsigned      n;
    int unsigned      phase;
    board       = new();
    calm        = 1'b0;
    frames_sent = 0;
    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = crcr_pkg::CFG_CAPTURE_ENABLE;
    cfg_data    = '0;
    frame_if.valid = 1'b0;
    frame_if.slot_0 = '0;
    frame_if.slot_1 = '0;
    frame_if.slot_2 = '0;
    frame_if.slot_3 = '0;
    frame_if.slot_4 = '0;
    frame_if.slot_5 = '0;
    frame_if.slot_6 = '0;
    frame_if.slot_7 = '0;
    frame_if.chunk_end = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // capture off after reset: frames are dropped
    send_frame(rand_frame());
    send_frame(rand_frame());

    // reset lengths, stereo, sixteen-bit, full and empty samples
    set_one(crcr_pkg::CFG_CAPTURE_ENABLE, 16'd1);
    f = '1;
    send_frame(f);
    f = '0;
    send_frame(f);

    // 5.1 and 7.1 in wide mode
    set_one(crcr_pkg::CFG_CHANNEL_LAYOUT, 16'(crcr_pkg::LAYOUT_51));
    set_one(crcr_pkg::CFG_SAMPLE_IS_WIDE, 16'd1);
    send_frame(rand_frame());
    f = '1;
    send_frame(f);
    set_one(crcr_pkg::CFG_CHANNEL_LAYOUT, 16'(crcr_pkg::LAYOUT_71));
    send_frame(rand_frame());

    // spare layout code, narrow
    configure(1'b1, LAYOUT_SPARE, 1'b0, 16'd4096, 16'd1024);
    f = '1;
    send_frame(f);

    // one-frame ring and period
    configure(1'b1, crcr_pkg::LAYOUT_STEREO, 1'b1, 16'd1, 16'd1);
    send_frame(rand_frame());
    send_frame(rand_frame());

    // zero ring, then zero period: dropped
    set_one(crcr_pkg::CFG_RING_FRAMES, 16'd0);
    send_frame(rand_frame());
    configure(1'b1, crcr_pkg::LAYOUT_STEREO, 1'b1, 16'd3, 16'd0);
    send_frame(rand_frame());

    // oversized lengths saturate
    configure(1'b1, crcr_pkg::LAYOUT_71, 1'b1, 16'hFFFF, 16'hFFFF);
    send_frame(rand_frame());
    send_frame(rand_frame());

    // fill part of a ring, then shrink ring and period below the counts
    configure(1'b1, crcr_pkg::LAYOUT_51, 1'b0, 16'd8, 16'd8);
    repeat (5) send_frame(rand_frame());
    configure(1'b1, crcr_pkg::LAYOUT_51, 1'b0, 16'd3, 16'd3);
    send_frame(rand_frame());
    send_frame(rand_frame());

    // random phases, each with its own register setting
    phase = 0;
    while (frames_sent < SENT_TARGET) begin
      configure($urandom_range(0, 9) != 0, 2'($urandom_range(0, 3)),
                1'($urandom_range(0, 1)), pick_len(), pick_len());
      n = $urandom_range(4, 30);
      for (int k = 0; k < n; k++) begin
        if (phase == 5 && k == n / 2) wait_drained();
        if (frames_sent >= CALM_FROM) calm = 1'b1;
        send_frame(rand_frame());
      end
      phase++;
    end

    // drain and report
    wait_drained();
    repeat (10) @(negedge clk_i);
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
sv/crcr_pkg.sv
sv/crcr_if.sv
sv/crcr_cfg_regs.sv
sv/crcr_in_stage.sv
sv/crcr_remap_stage.sv
sv/capture_ring_channel_remap.sv
tb/testbench.sv
